// ----- hw/rtl/enhanced_clock_page_victim_select_defines.svh -----
// Assertion macros used by the back end of the page victim selector.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef ENHANCED_CLOCK_PAGE_VICTIM_SELECT_DEFINES_SVH
`define ENHANCED_CLOCK_PAGE_VICTIM_SELECT_DEFINES_SVH

// Antecedent holds, so the consequent holds in the same cycle.
`define ECPVS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ecpvs check failed");

// Antecedent holds, so the consequent holds in the next cycle.
`define ECPVS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ecpvs check failed");

`endif

// ----- hw/rtl/ecpvs_pkg.sv -----
// Package of the page victim selector: sizes, codes and payload types.
// Used by every RTL module of the block; depends on nothing.
package ecpvs_pkg;

  localparam int NUM_PAGES = 4096;
  localparam int PAGE_W    = $clog2(NUM_PAGES);
  localparam int CNT_W     = PAGE_W + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVE_FREE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_START     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BREAK_SPAN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_EXECUTABLE = 3'd3;

  localparam logic [1:0] FUNC_SET    = 2'd0;
  localparam logic [1:0] FUNC_SCAN   = 2'd1;
  localparam logic [1:0] FUNC_REPORT = 2'd2;
  localparam logic [1:0] FUNC_CHOOSE = 2'd3;

  localparam logic [3:0] FLAG_PENDING   = 4'h8;
  localparam logic [3:0] FLAG_USER      = 4'h4;
  localparam logic [3:0] FLAG_DA        = 4'h3;
  localparam logic [3:0] FLAG_DIRTY     = 4'h2;
  localparam logic [3:0] KEEP_NO_ACCESS = 4'hE;
  localparam logic [3:0] KEEP_NO_USER   = 4'hB;

  localparam logic [12:0] RESERVE_RESET = 13'd256;

  localparam logic [2:0] STAGE_FREE   = 3'd0;
  localparam logic [2:0] STAGE_CLEAN1 = 3'd1;
  localparam logic [2:0] STAGE_DIRTY1 = 3'd2;
  localparam logic [2:0] STAGE_CLEAN2 = 3'd3;
  localparam logic [2:0] STAGE_DIRTY2 = 3'd4;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_SET,
    CMD_CLR_USER,
    CMD_REPORT,
    CMD_CHOOSE
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [11:0] page_index;
    logic [7:0]  ref_count;
    logic [3:0]  new_flags;
    logic [19:0] virt_page;
    logic        dirty;
    logic        accessed;
  } in_item_t;

  typedef struct packed {
    logic [11:0] victim_page;
    logic        found;
    logic [2:0]  stage;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [11:0] page;
    logic [7:0]  ref_count;
    logic [3:0]  flags;
  } cmd_t;

endpackage

// ----- hw/rtl/ecpvs_front.sv -----
// Front end: configuration registers and classification of input items.
// Depends on ecpvs_pkg; feeds the command queue.
module ecpvs_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  ecpvs_pkg::in_item_t                 in_item,
  input  logic                                cfg_we,
  input  logic [ecpvs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ecpvs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                q_full,
  input  logic                                clearing,
  output logic                                q_push,
  output ecpvs_pkg::cmd_t                     q_cmd,
  output logic [12:0]                         reserve_free
);

  logic [12:0] reserve_r;
  logic [31:0] code_start_r;
  logic [31:0] break_span_r;
  logic        has_exe_r;
  logic [31:0] win_end;
  logic [31:0] addr;
  logic        in_win;
  logic        in_range;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reserve_r    <= ecpvs_pkg::RESERVE_RESET;
      code_start_r <= '0;
      break_span_r <= '0;
      has_exe_r    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        ecpvs_pkg::CFG_RESERVE_FREE:   reserve_r    <= cfg_wdata[12:0];
        ecpvs_pkg::CFG_CODE_START:     code_start_r <= cfg_wdata;
        ecpvs_pkg::CFG_BREAK_SPAN:     break_span_r <= cfg_wdata;
        ecpvs_pkg::CFG_HAS_EXECUTABLE: has_exe_r    <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  assign win_end  = code_start_r + break_span_r;
  assign addr     = {in_item.virt_page, 12'h000};
  assign in_win   = has_exe_r && (addr >= code_start_r) && (addr < win_end);
  assign in_range = 32'(in_item.page_index) < ecpvs_pkg::NUM_PAGES;

  always_comb begin
    q_cmd.page      = in_item.page_index;
    q_cmd.ref_count = in_item.ref_count;
    q_cmd.flags     = in_item.new_flags;
    case (in_item.func)
      ecpvs_pkg::FUNC_SET:    q_cmd.kind = in_range ? ecpvs_pkg::CMD_SET : ecpvs_pkg::CMD_NOP;
      ecpvs_pkg::FUNC_SCAN:   q_cmd.kind = ecpvs_pkg::CMD_CLR_USER;
      ecpvs_pkg::FUNC_REPORT: begin
        q_cmd.kind  = in_range ? ecpvs_pkg::CMD_REPORT : ecpvs_pkg::CMD_NOP;
        q_cmd.flags = {1'b0, in_win, in_item.dirty, in_item.accessed};
      end
      ecpvs_pkg::FUNC_CHOOSE: q_cmd.kind = ecpvs_pkg::CMD_CHOOSE;
      default:                q_cmd.kind = ecpvs_pkg::CMD_NOP;
    endcase
  end

  assign in_full      = q_full || clearing;
  assign q_push       = in_push && !in_full;
  assign reserve_free = reserve_r;

endmodule

// ----- hw/rtl/ecpvs_cmd_q.sv -----
// Four-entry command queue between the front end and the back end.
// Depends on ecpvs_pkg for the command type.
module ecpvs_cmd_q (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ecpvs_pkg::cmd_t push_data,
  output logic            full,
  input  logic            pop,
  output ecpvs_pkg::cmd_t pop_data,
  output logic            empty
);

  ecpvs_pkg::cmd_t mem [4];
  logic [1:0] wr_ptr_r;
  logic [1:0] rd_ptr_r;
  logic [2:0] count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      count_r <= count_r + 3'(push) - 3'(pop);
    end
  end

  assign pop_data = mem[rd_ptr_r];
  assign empty    = count_r == 3'd0;
  assign full     = count_r == 3'd4;

endmodule

// ----- hw/rtl/ecpvs_back.sv -----
// Back end: page tables in memory, clock hand, scan sequencer, result register.
// Depends on ecpvs_pkg and the assertion macros in the defines header.
`include "enhanced_clock_page_victim_select_defines.svh"

module ecpvs_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  ecpvs_pkg::cmd_t       q_cmd,
  output logic                  q_pop,
  input  logic [12:0]           reserve_free,
  output logic                  clearing,
  output logic                  res_valid,
  output ecpvs_pkg::out_item_t  res_item,
  input  logic                  res_pop
);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_RMW} state_t;
  typedef enum logic [1:0] {MODE_FREE, MODE_CLEAN, MODE_DIRTY, MODE_USERCLR} mode_t;

  localparam logic [ecpvs_pkg::PAGE_W-1:0] LAST_PAGE = ecpvs_pkg::PAGE_W'(ecpvs_pkg::NUM_PAGES - 1);
  localparam logic [ecpvs_pkg::CNT_W-1:0]  ALL_PAGES = ecpvs_pkg::CNT_W'(ecpvs_pkg::NUM_PAGES);

  logic [7:0] ref_mem [ecpvs_pkg::NUM_PAGES];
  logic [3:0] flg_mem [ecpvs_pkg::NUM_PAGES];
  logic [7:0] rd_ref_r;
  logic [3:0] rd_flg_r;

  state_t                        state_r, state_nxt;
  mode_t                         mode_r, mode_nxt;
  logic                          round_r, round_nxt;
  logic [ecpvs_pkg::PAGE_W-1:0]  addr_r, addr_nxt;
  logic [ecpvs_pkg::CNT_W-1:0]   issued_r, issued_nxt;
  logic                          ev_valid_r, ev_valid_nxt;
  logic [ecpvs_pkg::PAGE_W-1:0]  ev_addr_r, ev_addr_nxt;
  logic [12:0]                   skip_r, skip_nxt;
  logic [ecpvs_pkg::PAGE_W-1:0]  hand_r, hand_nxt;
  ecpvs_pkg::cmd_t               cmd_r, cmd_nxt;
  logic                          res_valid_r, res_valid_nxt;
  ecpvs_pkg::out_item_t          res_r, res_nxt;

  logic [ecpvs_pkg::PAGE_W-1:0]  rd_addr;
  logic [ecpvs_pkg::PAGE_W-1:0]  wr_addr;
  logic                          ref_we;
  logic                          flg_we;
  logic [7:0]                    ref_wd;
  logic [3:0]                    flg_wd;
  logic                          eligible;
  logic                          hit;
  logic [2:0]                    hit_stage;
  logic                          start_pass;

  always_ff @(posedge clk) begin
    if (ref_we) begin
      ref_mem[wr_addr] <= ref_wd;
    end
    rd_ref_r <= ref_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (flg_we) begin
      flg_mem[wr_addr] <= flg_wd;
    end
    rd_flg_r <= flg_mem[rd_addr];
  end

  assign eligible = ((rd_flg_r & ecpvs_pkg::FLAG_PENDING) == 4'h0) &&
                    ((rd_flg_r & ecpvs_pkg::FLAG_USER) != 4'h0);

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    round_nxt     = round_r;
    addr_nxt      = addr_r;
    issued_nxt    = issued_r;
    ev_valid_nxt  = ev_valid_r;
    ev_addr_nxt   = ev_addr_r;
    skip_nxt      = skip_r;
    hand_nxt      = hand_r;
    cmd_nxt       = cmd_r;
    res_valid_nxt = res_valid_r && !res_pop;
    res_nxt       = res_r;
    q_pop         = 1'b0;
    rd_addr       = addr_r;
    wr_addr       = ev_addr_r;
    ref_we        = 1'b0;
    flg_we        = 1'b0;
    ref_wd        = 8'h00;
    flg_wd        = 4'h0;
    hit           = 1'b0;
    hit_stage     = ecpvs_pkg::STAGE_FREE;
    start_pass    = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        ref_we   = 1'b1;
        flg_we   = 1'b1;
        wr_addr  = addr_r;
        addr_nxt = addr_r + 1'b1;
        if (addr_r == LAST_PAGE) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty && !res_valid_r) begin
          q_pop = 1'b1;
          res_nxt = '0;
          case (q_cmd.kind)
            ecpvs_pkg::CMD_SET: begin
              ref_we        = 1'b1;
              flg_we        = 1'b1;
              wr_addr       = ecpvs_pkg::PAGE_W'(q_cmd.page);
              ref_wd        = q_cmd.ref_count;
              flg_wd        = q_cmd.flags;
              res_valid_nxt = 1'b1;
            end
            ecpvs_pkg::CMD_CLR_USER: begin
              mode_nxt   = MODE_USERCLR;
              start_pass = 1'b1;
            end
            ecpvs_pkg::CMD_REPORT: begin
              rd_addr   = ecpvs_pkg::PAGE_W'(q_cmd.page);
              cmd_nxt   = q_cmd;
              state_nxt = ST_RMW;
            end
            ecpvs_pkg::CMD_CHOOSE: begin
              mode_nxt   = MODE_FREE;
              round_nxt  = 1'b0;
              skip_nxt   = reserve_free;
              start_pass = 1'b1;
            end
            default: begin
              res_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_RMW: begin
        flg_we        = 1'b1;
        wr_addr       = ecpvs_pkg::PAGE_W'(cmd_r.page);
        flg_wd        = rd_flg_r | cmd_r.flags;
        res_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_SCAN: begin
        if (ev_valid_r) begin
          case (mode_r)
            MODE_FREE: begin
              if (rd_ref_r == 8'h00) begin
                if (skip_r != 13'd0) begin
                  skip_nxt = skip_r - 13'd1;
                end else begin
                  hit = 1'b1;
                end
              end
            end
            MODE_CLEAN: begin
              hit       = eligible && ((rd_flg_r & ecpvs_pkg::FLAG_DA) == 4'h0);
              hit_stage = round_r ? ecpvs_pkg::STAGE_CLEAN2 : ecpvs_pkg::STAGE_CLEAN1;
            end
            MODE_DIRTY: begin
              hit       = eligible &&
                          ((rd_flg_r & ecpvs_pkg::FLAG_DA) == ecpvs_pkg::FLAG_DIRTY);
              hit_stage = round_r ? ecpvs_pkg::STAGE_DIRTY2 : ecpvs_pkg::STAGE_DIRTY1;
              flg_we    = eligible && !hit;
              flg_wd    = rd_flg_r & ecpvs_pkg::KEEP_NO_ACCESS;
            end
            default: begin
              flg_we = 1'b1;
              flg_wd = rd_flg_r & ecpvs_pkg::KEEP_NO_USER;
            end
          endcase
        end

        if (hit) begin
          res_valid_nxt     = 1'b1;
          res_nxt.victim_page = 12'(ev_addr_r);
          res_nxt.found     = 1'b1;
          res_nxt.stage     = hit_stage;
          hand_nxt          = (ev_addr_r == '0) ? LAST_PAGE : ev_addr_r - 1'b1;
          ev_valid_nxt      = 1'b0;
          state_nxt         = ST_IDLE;
        end else if (issued_r != ALL_PAGES) begin
          ev_valid_nxt = 1'b1;
          ev_addr_nxt  = addr_r;
          addr_nxt     = (addr_r == '0) ? LAST_PAGE : addr_r - 1'b1;
          issued_nxt   = issued_r + 1'b1;
        end else begin
          ev_valid_nxt = 1'b0;
          if (!ev_valid_r) begin
            case (mode_r)
              MODE_FREE: begin
                mode_nxt   = MODE_CLEAN;
                start_pass = 1'b1;
              end
              MODE_CLEAN: begin
                mode_nxt   = MODE_DIRTY;
                start_pass = 1'b1;
              end
              MODE_DIRTY: begin
                if (!round_r) begin
                  round_nxt  = 1'b1;
                  mode_nxt   = MODE_CLEAN;
                  start_pass = 1'b1;
                end else begin
                  res_valid_nxt = 1'b1;
                  res_nxt       = '0;
                  state_nxt     = ST_IDLE;
                end
              end
              default: begin
                res_valid_nxt = 1'b1;
                res_nxt       = '0;
                state_nxt     = ST_IDLE;
              end
            endcase
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (start_pass) begin
      addr_nxt     = hand_r;
      issued_nxt   = '0;
      ev_valid_nxt = 1'b0;
      state_nxt    = ST_SCAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      mode_r      <= MODE_FREE;
      round_r     <= 1'b0;
      addr_r      <= '0;
      issued_r    <= '0;
      ev_valid_r  <= 1'b0;
      skip_r      <= '0;
      hand_r      <= LAST_PAGE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      round_r     <= round_nxt;
      addr_r      <= addr_nxt;
      issued_r    <= issued_nxt;
      ev_valid_r  <= ev_valid_nxt;
      skip_r      <= skip_nxt;
      hand_r      <= hand_nxt;
      res_valid_r <= res_valid_nxt;
    end
    ev_addr_r <= ev_addr_nxt;
    cmd_r     <= cmd_nxt;
    res_r     <= res_nxt;
  end

  assign clearing  = state_r == ST_CLEAR;
  assign res_valid = res_valid_r;
  assign res_item  = res_r;

  `ECPVS_ASSERT_SAME(a_no_pop_clear, state_r == ST_CLEAR, !q_pop)
  `ECPVS_ASSERT_SAME(a_eval_in_scan, ev_valid_r, state_r == ST_SCAN)
  `ECPVS_ASSERT_NEXT(a_res_hold, res_valid_r && !res_pop, res_valid_r && $stable(res_r))
  `ECPVS_ASSERT_SAME(a_stage_range, res_valid_r && !res_r.found, res_r.stage == ecpvs_pkg::STAGE_FREE)

endmodule

// ----- hw/rtl/enhanced_clock_page_victim_select.sv -----
// Top level of the page victim selector: front end, command queue, back end.
// Depends on ecpvs_pkg, ecpvs_front, ecpvs_cmd_q and ecpvs_back.
//
//   Channel  Ports                          Handshake
//   input    in_push, in_full, in_item      push and not full
//   result   out_empty, out_pop, out_item   pop and not empty
//   config   cfg_we, cfg_index, cfg_wdata   write enable
//
// After reset the page tables are cleared, with in_full held high.
// Set and out-of-range items finish in the idle state; report items then write back.
// Begin-scan sweeps every page, one flag word per cycle through the flag memory.
// A choose item takes up to five sweeps of 4096 pages.
// Up to four items wait in the command queue while a result waits to be popped.
module enhanced_clock_page_victim_select (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  ecpvs_pkg::in_item_t              in_item,
  output logic                             out_empty,
  input  logic                             out_pop,
  output ecpvs_pkg::out_item_t             out_item,
  input  logic                             cfg_we,
  input  logic [ecpvs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ecpvs_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic            q_push;
  logic            q_pop;
  logic            q_full;
  logic            q_empty;
  ecpvs_pkg::cmd_t q_in;
  ecpvs_pkg::cmd_t q_out;
  logic            clearing;
  logic [12:0]     reserve_free;
  logic            res_valid;

  ecpvs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_item      (in_item),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .q_full       (q_full),
    .clearing     (clearing),
    .q_push       (q_push),
    .q_cmd        (q_in),
    .reserve_free (reserve_free)
  );

  ecpvs_cmd_q u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  ecpvs_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_cmd        (q_out),
    .q_pop        (q_pop),
    .reserve_free (reserve_free),
    .clearing     (clearing),
    .res_valid    (res_valid),
    .res_item     (out_item),
    .res_pop      (out_pop)
  );

  assign out_empty = !res_valid;

endmodule

// ----- verif/tb_enhanced_clock_page_victim_select.sv -----
// Testbench of the page victim selector: directed and random transfers checked
// against a built-in model of the page tables. Depends on ecpvs_pkg and the RTL top.
module tb_enhanced_clock_page_victim_select;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk;
  logic rst_n;
  logic in_push;
  logic in_full;
  ecpvs_pkg::in_item_t in_item;
  logic out_empty;
  logic out_pop;
  ecpvs_pkg::out_item_t out_item;
  logic cfg_we;
  logic [ecpvs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [ecpvs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  enhanced_clock_page_victim_select u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  logic [7:0] pg_count [ecpvs_pkg::NUM_PAGES];
  logic [3:0] pg_flags [ecpvs_pkg::NUM_PAGES];
  logic [11:0] clock_hand;
  logic [12:0] reserve_cfg;
  logic [31:0] window_start;
  logic [31:0] window_span;
  logic exec_cfg;

  ecpvs_pkg::out_item_t victim_q[$];
  int mismatch_count = 0;
  bit steady = 0;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic ecpvs_pkg::out_item_t take_page(input logic [11:0] p,
                                                     input logic [2:0] st);
    ecpvs_pkg::out_item_t r;
    clock_hand = p - 12'd1;
    r.victim_page = p;
    r.found = 1'b1;
    r.stage = st;
    return r;
  endfunction

  function automatic ecpvs_pkg::out_item_t choose_victim();
    ecpvs_pkg::out_item_t r;
    logic [11:0] p;
    logic [3:0] f;
    int skip;
    skip = reserve_cfg;
    r = '0;
    for (int i = 0; i < ecpvs_pkg::NUM_PAGES; i++) begin
      p = clock_hand - 12'(i);
      if (pg_count[p] == 8'd0) begin
        if (skip > 0) begin
          skip--;
        end else begin
          return take_page(p, ecpvs_pkg::STAGE_FREE);
        end
      end
    end
    for (int rnd = 0; rnd < 2; rnd++) begin
      for (int i = 0; i < ecpvs_pkg::NUM_PAGES; i++) begin
        p = clock_hand - 12'(i);
        f = pg_flags[p];
        if ((f & ecpvs_pkg::FLAG_PENDING) == 0 && (f & ecpvs_pkg::FLAG_USER) != 0 &&
            (f & ecpvs_pkg::FLAG_DA) == 0)
          return take_page(p, rnd ? ecpvs_pkg::STAGE_CLEAN2 : ecpvs_pkg::STAGE_CLEAN1);
      end
      for (int i = 0; i < ecpvs_pkg::NUM_PAGES; i++) begin
        p = clock_hand - 12'(i);
        f = pg_flags[p];
        if ((f & ecpvs_pkg::FLAG_PENDING) == 0 && (f & ecpvs_pkg::FLAG_USER) != 0) begin
          if ((f & ecpvs_pkg::FLAG_DA) == ecpvs_pkg::FLAG_DIRTY)
            return take_page(p, rnd ? ecpvs_pkg::STAGE_DIRTY2 : ecpvs_pkg::STAGE_DIRTY1);
          pg_flags[p] = f & ecpvs_pkg::KEEP_NO_ACCESS;
        end
      end
    end
    return r;
  endfunction

  function automatic ecpvs_pkg::out_item_t predict_result(input ecpvs_pkg::in_item_t it);
    logic [31:0] addr;
    logic [3:0] f;
    predict_result = '0;
    case (it.func)
      ecpvs_pkg::FUNC_SET: begin
        pg_count[it.page_index] = it.ref_count;
        pg_flags[it.page_index] = it.new_flags;
      end
      ecpvs_pkg::FUNC_SCAN: begin
        for (int i = 0; i < ecpvs_pkg::NUM_PAGES; i++)
          pg_flags[i] = pg_flags[i] & ecpvs_pkg::KEEP_NO_USER;
      end
      ecpvs_pkg::FUNC_REPORT: begin
        addr = {it.virt_page, 12'h000};
        f = pg_flags[it.page_index];
        if (exec_cfg && addr >= window_start && addr < window_start + window_span)
          f = f | ecpvs_pkg::FLAG_USER;
        pg_flags[it.page_index] = f | {2'b00, it.dirty, it.accessed};
      end
      default: predict_result = choose_victim();
    endcase
  endfunction

  function automatic ecpvs_pkg::in_item_t make_item(input logic [1:0] fn,
                                                    input logic [11:0] pg,
                                                    input logic [7:0] rc,
                                                    input logic [3:0] fl,
                                                    input logic [19:0] vp,
                                                    input logic d,
                                                    input logic a);
    ecpvs_pkg::in_item_t it;
    it.func = fn;
    it.page_index = pg;
    it.ref_count = rc;
    it.new_flags = fl;
    it.virt_page = vp;
    it.dirty = d;
    it.accessed = a;
    return it;
  endfunction

  task automatic send_item(input ecpvs_pkg::in_item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    forever begin
      @(negedge clk);
      if (!in_full) break;
    end
    @(posedge clk);
    victim_q.push_back(predict_result(it));
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    while (victim_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ecpvs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      ecpvs_pkg::CFG_RESERVE_FREE: reserve_cfg = val[12:0];
      ecpvs_pkg::CFG_CODE_START: window_start = val;
      ecpvs_pkg::CFG_BREAK_SPAN: window_span = val;
      ecpvs_pkg::CFG_HAS_EXECUTABLE: exec_cfg = val[0];
      default: ;
    endcase
  endtask

  always begin
    int gap;
    ecpvs_pkg::out_item_t want;
    @(posedge clk);
    if (rst_n) begin
      gap = draw_gap();
      if (gap > 0) begin
        out_pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pop <= 1'b1;
      forever begin
        @(negedge clk);
        if (!out_empty) break;
      end
      want = out_item;
      @(posedge clk);
      if (victim_q.size() == 0) begin
        report_mismatch("result transfer with no expected result");
      end else begin
        want = victim_q.pop_front();
        if (out_item.victim_page != want.victim_page || out_item.found != want.found ||
            out_item.stage != want.stage)
          report_mismatch($sformatf("got page %0d found %0d stage %0d, want %0d %0d %0d",
                                    out_item.victim_page, out_item.found, out_item.stage,
                                    want.victim_page, want.found, want.stage));
      end
    end
  end

  int idle_count = 0;
  always @(negedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_count = 0;
    else idle_count++;
    if (idle_count >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_free_pick();
    send_item(make_item(ecpvs_pkg::FUNC_CHOOSE, 12'd0, 8'd0, 4'h0, 20'h0, 1'b0, 1'b0));
    send_item(make_item(ecpvs_pkg::FUNC_SET, 12'd3838, 8'hFF, 4'hF, 20'hFFFFF, 1'b1, 1'b1));
    send_item(make_item(ecpvs_pkg::FUNC_CHOOSE, 12'hFFF, 8'h0, 4'h0, 20'h0, 1'b1, 1'b1));
    wait_drained();
    write_reg(ecpvs_pkg::CFG_RESERVE_FREE, 32'd0);
    send_item(make_item(ecpvs_pkg::FUNC_CHOOSE, 12'd0, 8'd0, 4'h0, 20'h0, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_second_chance();
    logic [3:0] cases [5] = '{4'h7, 4'h5, 4'h6, 4'h4, 4'hC};
    wait_drained();
    write_reg(ecpvs_pkg::CFG_RESERVE_FREE, 32'd4096);
    foreach (cases[k]) begin
      send_item(make_item(ecpvs_pkg::FUNC_SET, k[0] ? 12'd0 : 12'hFFF, 8'd1, cases[k],
                          20'h0, 1'b0, 1'b0));
      send_item(make_item(ecpvs_pkg::FUNC_CHOOSE, 12'd0, 8'd0, 4'h0, 20'h0, 1'b0, 1'b0));
    end
  endtask

  task automatic test_window();
    wait_drained();
    write_reg(ecpvs_pkg::CFG_CODE_START, 32'h0040_0000);
    write_reg(ecpvs_pkg::CFG_BREAK_SPAN, 32'h0010_0000);
    write_reg(ecpvs_pkg::CFG_HAS_EXECUTABLE, 32'd1);
    send_item(make_item(ecpvs_pkg::FUNC_REPORT, 12'd10, 8'd0, 4'h0, 20'h00400, 1'b0, 1'b0));
    send_item(make_item(ecpvs_pkg::FUNC_REPORT, 12'd11, 8'd0, 4'h0, 20'h004FF, 1'b1, 1'b0));
    send_item(make_item(ecpvs_pkg::FUNC_REPORT, 12'd12, 8'd0, 4'h0, 20'h00500, 1'b0, 1'b1));
    send_item(make_item(ecpvs_pkg::FUNC_REPORT, 12'd13, 8'd0, 4'h0, 20'h003FF, 1'b1, 1'b1));
    send_item(make_item(ecpvs_pkg::FUNC_CHOOSE, 12'd0, 8'd0, 4'h0, 20'h0, 1'b0, 1'b0));
    wait_drained();
    write_reg(ecpvs_pkg::CFG_CODE_START, 32'hFFF0_0000);
    write_reg(ecpvs_pkg::CFG_BREAK_SPAN, 32'h0020_0000);
    send_item(make_item(ecpvs_pkg::FUNC_REPORT, 12'd14, 8'd0, 4'h0, 20'hFFF00, 1'b0, 1'b0));
    wait_drained();
    write_reg(ecpvs_pkg::CFG_CODE_START, 32'h0);
    write_reg(ecpvs_pkg::CFG_BREAK_SPAN, 32'hFFFF_FFFF);
    send_item(make_item(ecpvs_pkg::FUNC_REPORT, 12'd15, 8'd0, 4'h0, 20'hFFFFE, 1'b0, 1'b0));
  endtask

  task automatic test_scan_empty();
    send_item(make_item(ecpvs_pkg::FUNC_SCAN, 12'd0, 8'd0, 4'h0, 20'h0, 1'b0, 1'b0));
    send_item(make_item(ecpvs_pkg::FUNC_CHOOSE, 12'd0, 8'd0, 4'h0, 20'h0, 1'b0, 1'b0));
  endtask

  task automatic test_random(input int count);
    logic [1:0] fn;
    logic [11:0] pg;
    logic [19:0] vp;
    int w;
    for (int n = 0; n < count; n++) begin
      steady = (n % 40) >= 30;
      w = $urandom_range(0, 99);
      fn = w < 38 ? ecpvs_pkg::FUNC_SET : w < 68 ? ecpvs_pkg::FUNC_REPORT :
           w < 97 ? ecpvs_pkg::FUNC_CHOOSE : ecpvs_pkg::FUNC_SCAN;
      case ($urandom_range(0, 3))
        0: pg = 12'($urandom_range(0, 15));
        1: pg = 12'($urandom_range(4080, 4095));
        2: pg = clock_hand - 12'($urandom_range(0, 20));
        default: pg = 12'($urandom);
      endcase
      vp = $urandom_range(0, 1) ? 20'($urandom) : 20'h00400 + 20'($urandom_range(0, 255));
      send_item(make_item(fn, pg, $urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom),
                          4'($urandom), vp, 1'($urandom), 1'($urandom)));
    end
    steady = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    out_pop = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    for (int i = 0; i < ecpvs_pkg::NUM_PAGES; i++) begin
      pg_count[i] = '0;
      pg_flags[i] = '0;
    end
    clock_hand = 12'hFFF;
    reserve_cfg = ecpvs_pkg::RESERVE_RESET;
    window_start = '0;
    window_span = '0;
    exec_cfg = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_free_pick();
    test_second_chance();
    test_window();
    test_scan_empty();
    wait_drained();
    write_reg(ecpvs_pkg::CFG_CODE_START, 32'h0040_0000);
    write_reg(ecpvs_pkg::CFG_BREAK_SPAN, 32'h0008_0000);
    test_random(40);
    wait_drained();
    write_reg(ecpvs_pkg::CFG_RESERVE_FREE, 32'd2);
    test_random(30);
    wait_drained();
    write_reg(ecpvs_pkg::CFG_RESERVE_FREE, 32'd4096);
    write_reg(ecpvs_pkg::CFG_HAS_EXECUTABLE, 32'd0);
    test_random(30);

    wait_drained();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- enhanced_clock_page_victim_select.f -----
+incdir+hw/rtl
hw/rtl/ecpvs_pkg.sv
hw/rtl/ecpvs_front.sv
hw/rtl/ecpvs_cmd_q.sv
hw/rtl/ecpvs_back.sv
hw/rtl/enhanced_clock_page_victim_select.sv
verif/tb_enhanced_clock_page_victim_select.sv
